### rtl/core/pbv_pkg.sv
// ----------------------------------------------------------------------------
// pbv_pkg
// Shared types and constants of the projected box visibility test.
// ----------------------------------------------------------------------------
package pbv_pkg;

    localparam int SW = 66;
    localparam int DW = SW + 32;

    localparam logic REQ_ROW    = 1'b0;
    localparam logic REQ_VERTEX = 1'b1;

    localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic              req_type;
        logic [1:0]        row_index;
        logic signed [31:0] coef_col0;
        logic signed [31:0] coef_col1;
        logic signed [31:0] coef_col2;
        logic signed [31:0] coef_col3;
        logic signed [31:0] vert_x;
        logic signed [31:0] vert_y;
        logic signed [31:0] vert_z;
        logic              last_vertex;
    } t_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DSTART,
        ST_DITER,
        ST_BOX,
        ST_REPORT
    } t_state;

endpackage

### rtl/core/pbv_front.sv
// ----------------------------------------------------------------------------
// pbv_front
// Input side: accepts transactions and queues them for the back end.
// ----------------------------------------------------------------------------
module pbv_front import pbv_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    output logic   o_full,
    input  t_item  i_item,
    output logic   o_avail,
    input  logic   i_take,
    output t_item  o_item
);
    t_item      r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_wr, w_rd;

    assign o_full  = (r_cnt == 2'd2);
    assign o_avail = (r_cnt != 2'd0);
    assign o_item  = r_mem[r_rp];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_take && o_avail;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_wr) r_wp <= ~r_wp;
            if (w_rd) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_wr} - {1'b0, w_rd};
        end
    end
endmodule

### rtl/core/pbv_back.sv
// ----------------------------------------------------------------------------
// pbv_back
// Back end: matrix store, shared multiplier, serial divider, box and report.
// ----------------------------------------------------------------------------
module pbv_back import pbv_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_avail,
    output logic  o_take,
    input  t_item i_item,
    output logic  o_empty,
    input  logic  i_pop,
    output logic  o_visible,
    output logic  o_zero_w_seen
);
    localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;

    t_state r_st, n_st;
    logic signed [31:0] r_m [16];
    logic signed [31:0] r_v [3];
    logic               r_last;
    logic signed [SW-1:0] r_t [4];
    logic signed [63:0] r_prod;
    logic [3:0]  r_k;
    logic        r_ph;
    logic [1:0]  r_ax;
    logic [DW-1:0] r_rem, r_dsh;
    logic [4:0]  r_i;
    logic [31:0] r_q;
    logic        r_neg, r_sat, r_zw;
    logic signed [31:0] r_lo [3];
    logic signed [31:0] r_hi [3];
    logic        r_ov, r_vis, r_zws;

    logic signed [31:0] w_m;
    logic signed [63:0] w_sh;
    logic signed [SW-1:0] w_n, w_d;
    logic [SW-1:0] w_an, w_ad;
    logic        w_ge;
    logic signed [31:0] w_qs;
    logic        w_vis, w_free;

    assign w_m   = r_m[r_k];
    assign w_sh  = r_prod >>> FRAC_BITS;
    assign w_n   = r_t[r_ax];
    assign w_d   = r_t[3];
    assign w_an  = w_n[SW-1] ? SW'(-w_n) : SW'(w_n);
    assign w_ad  = w_d[SW-1] ? SW'(-w_d) : SW'(w_d);
    assign w_ge  = (r_rem >= r_dsh);
    assign w_free = !r_ov || i_pop;
    assign o_empty = !r_ov;
    assign o_visible = r_vis;
    assign o_zero_w_seen = r_zws;

    always_comb begin
        if (r_sat) w_qs = r_neg ? Q_MIN : Q_MAX;
        else       w_qs = r_neg ? -$signed(r_q) : $signed(r_q);
    end

    always_comb begin
        w_vis = 1'b1;
        for (int a = 0; a < 3; a++) begin
            logic signed [31:0] rmin;
            logic strad, insd;
            rmin  = (a == 2) ? 32'sd0 : -ONE;
            strad = (r_lo[a] < 0 && r_hi[a] > 0) || (r_lo[a] > 0 && r_hi[a] < 0);
            insd  = (r_lo[a] >= rmin && r_lo[a] <= ONE) ||
                    (r_hi[a] >= rmin && r_hi[a] <= ONE);
            if (!(strad || insd)) w_vis = 1'b0;
        end
    end

    always_comb begin
        n_st   = r_st;
        o_take = 1'b0;
        case (r_st)
            ST_IDLE: begin
                if (i_avail) begin
                    o_take = 1'b1;
                    if (i_item.req_type == REQ_VERTEX) n_st = ST_MUL;
                end
            end
            ST_MUL:    if (r_ph && r_k == 4'd15) n_st = ST_DSTART;
            ST_DSTART: n_st = (w_d == 0) ? ST_BOX : ST_DITER;
            ST_DITER:  if ((r_i == 5'd31 && w_ge) || r_i == 5'd0) n_st = ST_BOX;
            ST_BOX: begin
                if (r_ax != 2'd2) n_st = ST_DSTART;
                else              n_st = r_last ? ST_REPORT : ST_IDLE;
            end
            ST_REPORT: if (w_free) n_st = ST_IDLE;
            default:   n_st = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE;
            r_ov <= 1'b0;
            r_zw <= 1'b0;
            for (int i = 0; i < 16; i++) r_m[i] <= '0;
            for (int a = 0; a < 3; a++) begin
                r_lo[a] <= Q_MAX;
                r_hi[a] <= Q_MIN;
            end
        end else begin
            r_st <= n_st;
            if (r_st == ST_REPORT && w_free) r_ov <= 1'b1;
            else if (i_pop)                  r_ov <= 1'b0;
            case (r_st)
                ST_IDLE: begin
                    if (i_avail && i_item.req_type == REQ_ROW) begin
                        r_m[{i_item.row_index, 2'd0}] <= i_item.coef_col0;
                        r_m[{i_item.row_index, 2'd1}] <= i_item.coef_col1;
                        r_m[{i_item.row_index, 2'd2}] <= i_item.coef_col2;
                        r_m[{i_item.row_index, 2'd3}] <= i_item.coef_col3;
                    end
                end
                ST_DSTART: if (w_d == 0) r_zw <= 1'b1;
                ST_BOX: begin
                    if (w_qs < r_lo[r_ax]) r_lo[r_ax] <= w_qs;
                    if (w_qs > r_hi[r_ax]) r_hi[r_ax] <= w_qs;
                end
                ST_REPORT: begin
                    if (w_free) begin
                        r_zw <= 1'b0;
                        for (int a = 0; a < 3; a++) begin
                            r_lo[a] <= Q_MAX;
                            r_hi[a] <= Q_MIN;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_st)
            ST_IDLE: begin
                r_v[0] <= i_item.vert_x;
                r_v[1] <= i_item.vert_y;
                r_v[2] <= i_item.vert_z;
                r_last <= i_item.last_vertex;
                r_k    <= 4'd0;
                r_ph   <= 1'b0;
                r_ax   <= 2'd0;
                for (int i = 0; i < 4; i++) r_t[i] <= '0;
            end
            ST_MUL: begin
                if (!r_ph) begin
                    if (r_k[1:0] != 2'd3) r_prod <= w_m * r_v[r_k[1:0]];
                    r_ph <= 1'b1;
                end else begin
                    if (r_k[1:0] == 2'd3)
                        r_t[r_k[3:2]] <= r_t[r_k[3:2]] + {{(SW-32){w_m[31]}}, w_m};
                    else
                        r_t[r_k[3:2]] <= r_t[r_k[3:2]] + {{(SW-64){w_sh[63]}}, w_sh};
                    r_ph <= 1'b0;
                    r_k  <= r_k + 4'd1;
                end
            end
            ST_DSTART: begin
                r_neg <= (w_d == 0) ? w_n[SW-1] : (w_n[SW-1] != w_d[SW-1]);
                r_sat <= (w_d == 0) && (w_n != 0);
                r_q   <= '0;
                r_i   <= 5'd31;
                r_rem <= {{(DW-SW){1'b0}}, w_an} << FRAC_BITS;
                r_dsh <= {{(DW-SW){1'b0}}, w_ad} << 31;
            end
            ST_DITER: begin
                if (r_i == 5'd31) begin
                    if (w_ge) r_sat <= 1'b1;
                end else if (w_ge) begin
                    r_rem      <= r_rem - r_dsh;
                    r_q[r_i]   <= 1'b1;
                end
                r_dsh <= r_dsh >> 1;
                r_i   <= r_i - 5'd1;
            end
            ST_BOX: r_ax <= r_ax + 2'd1;
            ST_REPORT: begin
                if (w_free) begin
                    r_vis <= w_vis;
                    r_zws <= r_zw;
                end
            end
            default: ;
        endcase
    end
endmodule

### rtl/core/projected_box_visibility_test.sv
// ----------------------------------------------------------------------------
// projected_box_visibility_test
// Projects mesh vertices by a loaded 4x4 matrix and tests the screen box.
// ----------------------------------------------------------------------------
// A row load goes straight into the matrix store. A vertex is taken, run on the
// single 32x32 multiplier (12 products plus 4 translation adds, each in a multiply
// and an accumulate phase) and then once per axis on the one-bit-per-cycle
// divider (stopping early when w is zero or the quotient saturates); the last
// vertex also makes the report. A two-entry input queue takes new transactions
// while a vertex is in flight; one result register holds the report until popped.
module projected_box_visibility_test import pbv_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic        i_req_type,
    input  logic [1:0]  i_row_index,
    input  logic signed [31:0] i_coef_col0,
    input  logic signed [31:0] i_coef_col1,
    input  logic signed [31:0] i_coef_col2,
    input  logic signed [31:0] i_coef_col3,
    input  logic signed [31:0] i_vert_x,
    input  logic signed [31:0] i_vert_y,
    input  logic signed [31:0] i_vert_z,
    input  logic        i_last_vertex,
    output logic        empty,
    input  logic        pop,
    output logic        o_visible,
    output logic        o_zero_w_seen
);
    t_item w_in, w_q;
    logic  w_avail, w_take;

    assign w_in = '{req_type: i_req_type, row_index: i_row_index,
                    coef_col0: i_coef_col0, coef_col1: i_coef_col1,
                    coef_col2: i_coef_col2, coef_col3: i_coef_col3,
                    vert_x: i_vert_x, vert_y: i_vert_y, vert_z: i_vert_z,
                    last_vertex: i_last_vertex};

    pbv_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .o_full(full),
        .i_item(w_in), .o_avail(w_avail), .i_take(w_take), .o_item(w_q)
    );

    pbv_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_avail(w_avail), .o_take(w_take),
        .i_item(w_q), .o_empty(empty), .i_pop(pop), .o_visible(o_visible),
        .o_zero_w_seen(o_zero_w_seen)
    );
endmodule

### rtl/core/pbv_checker.sv
// ----------------------------------------------------------------------------
// pbv_checker
// Port-level checks of the visibility test, bound to the top level.
// ----------------------------------------------------------------------------
module pbv_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic full,
    input logic empty,
    input logic pop,
    input logic o_visible,
    input logic o_zero_w_seen
);
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result queue not empty after reset");
    a_rst_full: assert property (@(posedge i_clk) !i_rst_n |=> !full)
        else $error("input queue full after reset");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_visible) && $stable(o_zero_w_seen))
        else $error("waiting result changed");
endmodule

bind projected_box_visibility_test pbv_checker u_pbv_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .full(full), .empty(empty), .pop(pop),
    .o_visible(o_visible), .o_zero_w_seen(o_zero_w_seen)
);

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives matrix row loads and mesh vertices into the projected box visibility
// test, predicts each report with an independent fixed point projection and
// box model, and checks every popped report field by field.
// ----------------------------------------------------------------------------
module testbench;
    import pbv_pkg::*;

    localparam int  FRAC      = 16;
    localparam int  LIMIT     = 1000000;
    localparam int  FULL_HOLD = 400;

    typedef struct {
        logic visible;
        logic zero_w;
    } t_report;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic        i_req_type = 1'b0;
    logic [1:0]  i_row_index = '0;
    logic signed [31:0] i_coef_col0 = '0, i_coef_col1 = '0, i_coef_col2 = '0;
    logic signed [31:0] i_coef_col3 = '0;
    logic signed [31:0] i_vert_x = '0, i_vert_y = '0, i_vert_z = '0;
    logic        i_last_vertex = 1'b0;
    logic        empty;
    logic        pop = 1'b0;
    logic        o_visible;
    logic        o_zero_w_seen;

    logic signed [31:0] mtx [16];
    logic signed [31:0] box_lo [3];
    logic signed [31:0] box_hi [3];
    logic               zw_flag;
    t_report            report_q [$];
    int                 errors = 0;
    int                 cycles = 0;
    bit                 calm = 1'b0;
    bit                 hold_req = 1'b0;

    always #1 i_clk = ~i_clk;

    projected_box_visibility_test #(.FRAC_BITS(FRAC)) uut (.*);

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("testbench failed");
            $finish;
        end
    end

    function automatic logic signed [31:0] quotient(longint n, longint d);
        logic        neg;
        logic [63:0] an, ad, q;
        logic [127:0] w;
        neg = (n < 0) != (d < 0);
        if (d == 0) begin
            zw_flag = 1'b1;
            return n > 0 ? Q_MAX : (n < 0 ? Q_MIN : 32'sd0);
        end
        an = n < 0 ? 64'(-n) : 64'(n);
        ad = d < 0 ? 64'(-d) : 64'(d);
        q  = an / ad;
        if (q >= (64'd1 << (31 - FRAC))) return neg ? Q_MIN : Q_MAX;
        w = ({64'd0, an} << FRAC) / {64'd0, ad};
        return neg ? -w[31:0] : w[31:0];
    endfunction

    function automatic void clear_box();
        for (int a = 0; a < 3; a++) begin
            box_lo[a] = Q_MAX;
            box_hi[a] = Q_MIN;
        end
        zw_flag = 1'b0;
    endfunction

    function automatic void project_item(t_item it);
        longint             t [4];
        longint             v [3];
        longint             lo, hi, rmin;
        logic signed [31:0] q;
        t_report            rep;
        if (it.req_type == REQ_ROW) begin
            mtx[it.row_index*4+0] = it.coef_col0;
            mtx[it.row_index*4+1] = it.coef_col1;
            mtx[it.row_index*4+2] = it.coef_col2;
            mtx[it.row_index*4+3] = it.coef_col3;
            return;
        end
        v[0] = it.vert_x;
        v[1] = it.vert_y;
        v[2] = it.vert_z;
        for (int r = 0; r < 4; r++) begin
            t[r] = longint'(mtx[r*4+3]);
            for (int c = 0; c < 3; c++)
                t[r] += (longint'(mtx[r*4+c]) * v[c]) >>> FRAC;
        end
        for (int a = 0; a < 3; a++) begin
            q = quotient(t[a], t[3]);
            if (q < box_lo[a]) box_lo[a] = q;
            if (q > box_hi[a]) box_hi[a] = q;
        end
        if (!it.last_vertex) return;
        rep.visible = 1'b1;
        for (int a = 0; a < 3; a++) begin
            lo   = box_lo[a];
            hi   = box_hi[a];
            rmin = (a == 2) ? 0 : -(64'sd1 << FRAC);
            if (!((lo < 0 && hi > 0) || (lo > 0 && hi < 0) ||
                  (lo >= rmin && lo <= (64'sd1 << FRAC)) ||
                  (hi >= rmin && hi <= (64'sd1 << FRAC))))
                rep.visible = 1'b0;
        end
        rep.zero_w = zw_flag;
        report_q.insert(report_q.size(), rep);
        clear_box();
    endfunction

    // receiver: random pop bursts, one long hold-off on request
    initial begin
        int hold;
        hold = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                hold = FULL_HOLD;
            end
            if (hold > 0) begin
                pop <= 1'b0;
                hold--;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                pop <= 1'b0;
                hold = $urandom_range(1, 12) - 1;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_report exp_rep;
        if (i_rst_n && pop && !empty) begin
            if (report_q.size() == 0) begin
                $error("unexpected report: visible %0b zero_w_seen %0b",
                       o_visible, o_zero_w_seen);
                errors++;
            end else begin
                exp_rep = report_q.pop_front();
                if (o_visible !== exp_rep.visible) begin
                    $error("visible: expected %0b actual %0b", exp_rep.visible, o_visible);
                    errors++;
                end
                if (o_zero_w_seen !== exp_rep.zero_w) begin
                    $error("zero_w_seen: expected %0b actual %0b",
                           exp_rep.zero_w, o_zero_w_seen);
                    errors++;
                end
            end
        end
    end

    task automatic send_item(t_item it);
        if (!calm && $urandom_range(0, 7) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        push          <= 1'b1;
        i_req_type    <= it.req_type;
        i_row_index   <= it.row_index;
        i_coef_col0   <= it.coef_col0;
        i_coef_col1   <= it.coef_col1;
        i_coef_col2   <= it.coef_col2;
        i_coef_col3   <= it.coef_col3;
        i_vert_x      <= it.vert_x;
        i_vert_y      <= it.vert_y;
        i_vert_z      <= it.vert_z;
        i_last_vertex <= it.last_vertex;
        do @(posedge i_clk); while (full);
        project_item(it);
    endtask

    function automatic logic signed [31:0] rnd32();
        return $urandom();
    endfunction

    function automatic logic signed [31:0] rnd_fix(int mag);
        return $signed($urandom_range(0, 2 * mag)) - mag;
    endfunction

    task automatic load_row(int r, logic signed [31:0] c0, logic signed [31:0] c1,
                            logic signed [31:0] c2, logic signed [31:0] c3);
        t_item it;
        it = '{REQ_ROW, 2'(r), c0, c1, c2, c3, rnd32(), rnd32(), rnd32(), 1'($urandom())};
        send_item(it);
    endtask

    task automatic send_vertex(logic signed [31:0] x, logic signed [31:0] y,
                               logic signed [31:0] z, logic last);
        t_item it;
        it = '{REQ_VERTEX, 2'($urandom()), rnd32(), rnd32(), rnd32(), rnd32(), x, y, z, last};
        send_item(it);
    endtask

    task automatic load_identity();
        load_row(0, 32'sh1_0000, 0, 0, 0);
        load_row(1, 0, 32'sh1_0000, 0, 0);
        load_row(2, 0, 0, 32'sh1_0000, 0);
        load_row(3, 0, 0, 0, 32'sh1_0000);
    endtask

    task automatic test_zero_matrix();
        // all-zero matrix after reset: w is zero, numerator zero
        send_vertex(Q_MAX, Q_MIN, 0, 1'b1);
    endtask

    task automatic test_identity_boxes();
        load_identity();
        send_vertex(32'sh8000, 32'sh8000, 32'sh8000, 1'b1);
        send_vertex(-32'sh3_0000, -32'sh3_0000, 32'sh5_0000, 1'b0);
        send_vertex(32'sh3_0000, 32'sh3_0000, -32'sh2_0000, 1'b1);
        send_vertex(32'sh5_0000, 32'sh1_0000, 32'sh1_0000, 1'b0);
        send_vertex(32'sh6_0000, 32'sh1_0000, 32'sh1_0000, 1'b1);
        send_vertex(-32'sh1_0000, 32'sh1_0000, 0, 1'b1);
        send_vertex(Q_MAX, Q_MIN, Q_MAX, 1'b1);
    endtask

    task automatic test_zero_and_overflow_w();
        load_row(3, 32'sh1_0000, 0, 0, 0);
        send_vertex(0, 32'sh2_0000, -32'sh2_0000, 1'b1);
        send_vertex(32'sh1, 32'sh7FFF_0000, 32'sh1, 1'b0);
        send_vertex(-32'sh1, -32'sh7FFF_0000, 32'sh1, 1'b1);
        load_row(3, 0, 0, 0, 32'sh1);
        send_vertex(32'sh4000_0000, -32'sh4000_0000, 32'sh1, 1'b1);
        load_row(3, Q_MIN, Q_MAX, Q_MIN, Q_MAX);
        send_vertex(Q_MIN, Q_MAX, Q_MIN, 1'b1);
    endtask

    task automatic load_random_matrix();
        int mode;
        for (int r = 0; r < 4; r++) begin
            mode = $urandom_range(0, 9);
            if (mode == 0)
                load_row(r, rnd32(), rnd32(), rnd32(), rnd32());
            else if (r == 3 && mode < 6)
                load_row(r, rnd_fix(32'h1000), rnd_fix(32'h1000), rnd_fix(32'h4000),
                         rnd_fix(32'h4_0000) + 32'sh4_0000);
            else
                load_row(r, rnd_fix(32'h2_0000), rnd_fix(32'h2_0000), rnd_fix(32'h2_0000),
                         rnd_fix(32'h2_0000));
        end
    endtask

    task automatic random_mesh(output int n);
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 19) == 0)
                send_vertex(rnd32(), rnd32(), rnd32(), i == n - 1);
            else
                send_vertex(rnd_fix(32'h8_0000), rnd_fix(32'h8_0000), rnd_fix(32'h8_0000),
                            i == n - 1);
        end
    endtask

    task automatic test_random_meshes(int items);
        int sent;
        int n_mesh;
        sent = 0;
        while (sent < items) begin
            if ($urandom_range(0, 3) == 0) begin
                load_random_matrix();
                sent += 4;
            end else if ($urandom_range(0, 15) == 0) begin
                // stray vertex or single row, breaking the usual sequence
                if ($urandom_range(0, 1))
                    load_row($urandom_range(0, 3), rnd32(), rnd32(), rnd32(), rnd32());
                else
                    send_vertex(rnd32(), rnd32(), rnd32(), 1'($urandom()));
                sent++;
            end else begin
                random_mesh(n_mesh);
                sent += n_mesh;
            end
        end
    endtask

    task automatic test_backpressure();
        hold_req = 1'b1;
        for (int i = 0; i < 12; i++)
            send_vertex(rnd_fix(32'h2_0000), rnd_fix(32'h2_0000), rnd_fix(32'h2_0000), 1'b1);
        push <= 1'b0;
        wait (report_q.size() == 0);
        @(posedge i_clk);
    endtask

    initial begin
        for (int i = 0; i < 16; i++) mtx[i] = '0;
        clear_box();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_zero_matrix();
        test_identity_boxes();
        test_zero_and_overflow_w();
        test_backpressure();
        test_random_meshes(600);
        test_backpressure();
        calm = 1'b1;
        test_random_meshes(200);
        push <= 1'b0;
        wait (report_q.size() == 0);
        repeat (300) @(posedge i_clk);
        if (errors == 0 && report_q.size() == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end
endmodule
